// ----- hw/rtl/multi_atlas_shelf_packer_assert.svh -----
// Assertion macros for the multi-atlas shelf packer.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef MULTI_ATLAS_SHELF_PACKER_ASSERT_SVH
`define MULTI_ATLAS_SHELF_PACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define MSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds
`define MSP_ASSERT_NEVER(lbl, cond, msg) \
  `MSP_ASSERT(lbl, !(cond), msg)
`else
`define MSP_ASSERT(lbl, prop, msg)
`define MSP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/msp_pkg.sv -----
// Shared types, codes and constants of the multi-atlas shelf packer.
// No dependencies; every other module imports it.
package msp_pkg;

  // Field widths fixed by the interface
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned RW_W        = DIM_W + 1;  // size plus padding on both sides
  localparam int unsigned PAD_W       = 4;
  localparam int unsigned IDX_OUT_W   = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Parameter defaults
  localparam int unsigned DEF_MAX_ATLAS_COUNT = 8;
  localparam int unsigned DEF_COORD_WIDTH     = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING      = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_ATLAS_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_ATLAS_HEIGHT = 13'd1024;
  localparam logic [PAD_W-1:0] RST_PADDING      = 4'd1;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  // Request class decided by the front end
  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_EMPTY     = 2'd1,
    CMD_TOO_LARGE = 2'd2,
    CMD_ALLOC     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCAN  = 2'd1,
    BK_PLACE = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e              operation;
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;
    logic             has_bitmap;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] atlas_index;
    logic [DIM_W-1:0]     pos_x;
    logic [DIM_W-1:0]     pos_y;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] atlas_width;
    logic [DIM_W-1:0] atlas_height;
    logic [PAD_W-1:0] padding;
  } cfg_t;

  // Classified request carried from front to back
  typedef struct packed {
    cmd_e            kind;
    logic [RW_W-1:0] rw;
    logic [RW_W-1:0] rh;
  } cmd_t;

endpackage

// ----- hw/rtl/multi_atlas_shelf_packer.sv -----
// Top level of the multi-atlas shelf packer: config registers, request queue,
// front end, back end and result queue. Depends on msp_pkg, msp_fifo, msp_front, msp_back.
//
//   channel   direction  handshake                 payload
//   request   in         push / full               item_i (in_item_t)
//   result    out        empty / pop               result_o (result_t)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request is queued at the edge it is pushed; the back end answers clear, empty and
// too-large requests straight from its idle state. An allocation is taken in the idle
// state; the first-fit scan sequencer then checks each open atlas in turn, opens a new
// atlas or reports no space when none fits, and writes a placement in its place state.
// Reset is asynchronous and active low; it leaves one empty atlas open. A stalled
// result side fills the two-entry result queue and then holds the back end.
module multi_atlas_shelf_packer import msp_pkg::*; #(
  parameter int unsigned MAX_ATLAS_COUNT = DEF_MAX_ATLAS_COUNT,
  parameter int unsigned COORD_WIDTH     = DEF_COORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             item_i,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    front_cmd, back_cmd;
  logic    cmd_empty, cmd_pop;
  logic    res_full, res_push;
  result_t back_res;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; other indexes do nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_width  <= RST_ATLAS_WIDTH;
      cfg_q.atlas_height <= RST_ATLAS_HEIGHT;
      cfg_q.padding      <= RST_PADDING;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ATLAS_WIDTH:  cfg_q.atlas_width  <= cfg_data_i;
        CFG_ATLAS_HEIGHT: cfg_q.atlas_height <= cfg_data_i;
        CFG_PADDING:      cfg_q.padding      <= cfg_data_i[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify incoming requests
  msp_front u_front (
    .item_i (item_i),
    .cfg_i  (cfg_q),
    .cmd_o  (front_cmd)
  );

  // Queue classified requests toward the back end
  msp_fifo #(
    .DATA_W ($bits(cmd_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  // Carry out requests against the atlas state
  msp_back #(
    .MAX_ATLAS_COUNT (MAX_ATLAS_COUNT),
    .COORD_WIDTH     (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Buffer results for the consumer
  msp_fifo #(
    .DATA_W ($bits(result_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// ----- hw/rtl/msp_fifo.sv -----
// Small first-in first-out queue of the shelf packer.
// Depends on msp_pkg for its default depth.
module msp_fifo import msp_pkg::*; #(
  parameter int unsigned DATA_W = $bits(result_t),
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]    LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wptr_q, wptr_d;
  logic [PW-1:0]     rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/msp_front.sv -----
// Front end of the shelf packer: classifies each request and pads its size.
// Depends on msp_pkg.
module msp_front import msp_pkg::*; (
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output cmd_t     cmd_o
);

  logic [RW_W-1:0] pad2;
  logic [RW_W-1:0] rw, rh;
  logic            is_empty, too_large;

  // Pad the rectangle on both sides
  assign pad2 = RW_W'({cfg_i.padding, 1'b0});
  assign rw   = RW_W'(item_i.glyph_width) + pad2;
  assign rh   = RW_W'(item_i.glyph_height) + pad2;

  assign is_empty  = !item_i.has_bitmap || (item_i.glyph_width == '0) ||
                     (item_i.glyph_height == '0);
  assign too_large = (rw > RW_W'(cfg_i.atlas_width)) || (rh > RW_W'(cfg_i.atlas_height));

  // Classify: clear first, then empty glyph, then size check
  always_comb begin
    cmd_o.rw = rw;
    cmd_o.rh = rh;
    if (item_i.operation == OP_CLEAR) begin
      cmd_o.kind = CMD_CLEAR;
    end else if (is_empty) begin
      cmd_o.kind = CMD_EMPTY;
    end else if (too_large) begin
      cmd_o.kind = CMD_TOO_LARGE;
    end else begin
      cmd_o.kind = CMD_ALLOC;
    end
  end

endmodule

// ----- hw/rtl/msp_back.sv -----
// Back end of the shelf packer: atlas state and the first-fit scan sequencer.
// Depends on msp_pkg and multi_atlas_shelf_packer_assert.svh.
`include "multi_atlas_shelf_packer_assert.svh"
module msp_back import msp_pkg::*; #(
  parameter int unsigned MAX_ATLAS_COUNT = DEF_MAX_ATLAS_COUNT,
  parameter int unsigned COORD_WIDTH     = DEF_COORD_WIDTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int unsigned AW    = (MAX_ATLAS_COUNT > 1) ? $clog2(MAX_ATLAS_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ATLAS_COUNT + 1);
  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned SUM_W = ((CW > RW_W) ? CW : RW_W) + 2;
  localparam int unsigned POS_W = ((CW > PAD_W) ? CW : PAD_W) + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ATLAS_COUNT);

  // Per-atlas state
  logic [CW-1:0]              cursor_q [MAX_ATLAS_COUNT];
  logic [CW-1:0]              base_q   [MAX_ATLAS_COUNT];
  logic [CW-1:0]              height_q [MAX_ATLAS_COUNT];
  logic [MAX_ATLAS_COUNT-1:0] full_q;
  logic [CNT_W-1:0]           open_q;

  // Sequencer state
  back_state_e      state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [RW_W-1:0]  rw_q, rw_d, rh_q, rh_d;

  logic clear_all, mark_full, open_new, place_we;

  logic [AW-1:0]    rd_a;
  logic [CW-1:0]    rd_cursor, rd_base, rd_height;
  logic [CW:0]      base_sum;
  logic [SUM_W-1:0] cur_sum, base_rh, next_row;
  logic             fit_cur, fit_new;
  logic [CW-1:0]    row_base_n, cursor_b, height_b, new_cursor, new_height;
  logic [POS_W-1:0] px, py;
  result_t          res;

  // Read the atlas under the scan index
  assign rd_a      = idx_q[AW-1:0];
  assign rd_cursor = cursor_q[rd_a];
  assign rd_base   = base_q[rd_a];
  assign rd_height = height_q[rd_a];

  // Fit tests against the current atlas size
  assign base_sum = (CW+1)'(rd_base) + (CW+1)'(rd_height);
  assign cur_sum  = SUM_W'(rd_cursor) + SUM_W'(rw_q);
  assign base_rh  = SUM_W'(rd_base) + SUM_W'(rh_q);
  assign next_row = SUM_W'(base_sum) + SUM_W'(rh_q);
  assign fit_cur  = (cur_sum <= SUM_W'(cfg_i.atlas_width)) &&
                    (base_rh <= SUM_W'(cfg_i.atlas_height));
  assign fit_new  = (next_row <= SUM_W'(cfg_i.atlas_height)) &&
                    (SUM_W'(rw_q) <= SUM_W'(cfg_i.atlas_width));

  // Placement: start a new row when the current one cannot take it
  assign row_base_n = fit_cur ? rd_base : base_sum[CW-1:0];
  assign cursor_b   = fit_cur ? rd_cursor : '0;
  assign height_b   = fit_cur ? rd_height : '0;
  assign px         = POS_W'(cursor_b) + POS_W'(cfg_i.padding);
  assign py         = POS_W'(row_base_n) + POS_W'(cfg_i.padding);
  assign new_cursor = CW'(SUM_W'(cursor_b) + SUM_W'(rw_q));
  assign new_height = (SUM_W'(rh_q) > SUM_W'(height_b)) ? CW'(rh_q) : height_b;

  assign res_o = res;

  // Next state and outputs
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rw_d       = rw_q;
    rh_d       = rh_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res        = '0;
    clear_all  = 1'b0;
    mark_full  = 1'b0;
    open_new   = 1'b0;
    place_we   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_CLEAR: begin
              clear_all  = 1'b1;
              res_push_o = 1'b1;
              res.status = ST_CLEARED;
            end
            CMD_EMPTY: begin
              res_push_o = 1'b1;
              res.status = ST_EMPTY;
            end
            CMD_TOO_LARGE: begin
              res_push_o = 1'b1;
              res.status = ST_TOO_LARGE;
            end
            CMD_ALLOC: begin
              rw_d    = cmd_i.rw;
              rh_d    = cmd_i.rh;
              idx_d   = '0;
              state_d = BK_SCAN;
            end
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        if (idx_q < open_q) begin
          if (full_q[rd_a]) begin
            idx_d = idx_q + CNT_W'(1);
          end else if (fit_cur || fit_new) begin
            state_d = BK_PLACE;
          end else begin
            mark_full = 1'b1;
            idx_d     = idx_q + CNT_W'(1);
          end
        end else if (open_q < MAX_CNT) begin
          // Open the next atlas; the index already points at it
          open_new = 1'b1;
          state_d  = BK_PLACE;
        end else begin
          res_push_o = 1'b1;
          res.status = ST_NO_SPACE;
          state_d    = BK_IDLE;
        end
      end
      BK_PLACE: begin
        place_we        = 1'b1;
        res_push_o      = 1'b1;
        res.status      = ST_PLACED;
        res.atlas_index = IDX_OUT_W'(idx_q);
        res.pos_x       = DIM_W'(px);
        res.pos_y       = DIM_W'(py);
        state_d         = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer and atlas state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      open_q  <= CNT_W'(1);
      full_q  <= '0;
      for (int i = 0; i < MAX_ATLAS_COUNT; i++) begin
        cursor_q[i] <= '0;
        base_q[i]   <= '0;
        height_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      // Empty every atlas, keep the open count
      if (clear_all) begin
        full_q <= '0;
        for (int i = 0; i < MAX_ATLAS_COUNT; i++) begin
          cursor_q[i] <= '0;
          base_q[i]   <= '0;
          height_q[i] <= '0;
        end
      end
      if (mark_full) begin
        full_q[rd_a] <= 1'b1;
      end
      if (open_new) begin
        cursor_q[rd_a] <= '0;
        base_q[rd_a]   <= '0;
        height_q[rd_a] <= '0;
        full_q[rd_a]   <= 1'b0;
        open_q         <= open_q + CNT_W'(1);
      end
      if (place_we) begin
        cursor_q[rd_a] <= new_cursor;
        base_q[rd_a]   <= row_base_n;
        height_q[rd_a] <= new_height;
      end
    end
  end

  // Hold the padded size of the request under work
  always_ff @(posedge clk_i) begin
    rw_q <= rw_d;
    rh_q <= rh_d;
  end

  `MSP_ASSERT(a_open_range, (open_q != '0) && (open_q <= MAX_CNT), "open count out of range")
  `MSP_ASSERT(a_res_room, res_push_o |-> !res_full_i, "result written into full queue")
  `MSP_ASSERT(a_scan_bound, (state_q == BK_SCAN) |-> (idx_q <= open_q), "scan past open atlases")
  `MSP_ASSERT(a_place_bound, (state_q == BK_PLACE) |-> (idx_q < open_q), "placing in closed atlas")
  `MSP_ASSERT(a_clear_empties, clear_all |=> (full_q == '0), "clear left a full mark")
  `MSP_ASSERT_NEVER(a_pop_busy, cmd_pop_o && (state_q != BK_IDLE), "request taken while busy")

endmodule
